// ----- rtl/svpt_pkg.sv -----
package svpt_pkg;

	localparam int VOLT_W = 16;
	localparam int VDC_W  = 15;
	localparam int TICK_W = 16;
	localparam int DUTY_W = 16;
	localparam int FRAC_W = 24;

	localparam logic [24:0] SQRT3_Q24 = 25'd29058991;

	// widths of the projection path
	localparam int U_W   = 42;              // b * sqrt3 in Q24, signed
	localparam int P_W   = 44;              // edge projections, signed
	localparam int W_W   = 42;              // clamped projections
	localparam int SUM_W = W_W + 1;
	localparam int DEN_W = VDC_W + FRAC_W + 1;
	localparam int HALF_W = W_W / 2;
	localparam int PP_W  = TICK_W + HALF_W;
	localparam int REM_W = TICK_W + W_W + 1;

	// time division: quotient bounded by the period
	localparam int TQ_W = TICK_W;
	// duty division: quotient bounded by 2^DUTY_W
	localparam int DQ_W  = DUTY_W + 1;
	localparam int DX_W  = TICK_W + 1;
	localparam int DN_W  = DX_W + DUTY_W + 1;

	localparam logic [TICK_W-1:0] PERIOD_RST = TICK_W'(5000);
	localparam logic [DUTY_W-1:0] DUTY_FULL  = '1;

	typedef enum logic [0:0] {
		REG_PERIOD = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem1;
		logic [REM_W-1:0]  rem2;
		logic [TQ_W-1:0]   q1;
		logic [TQ_W-1:0]   q2;
		logic [SUM_W-1:0]  d1;
		logic [SUM_W-1:0]  d2;
		logic [TICK_W-1:0] ts;
		logic [2:0]        k;
		logic              sat;
		logic              inv;
	} tdiv_t;

	typedef struct packed {
		logic [DN_W-1:0]   rem_a;
		logic [DN_W-1:0]   rem_b;
		logic [DN_W-1:0]   rem_c;
		logic [DQ_W-1:0]   q_a;
		logic [DQ_W-1:0]   q_b;
		logic [DQ_W-1:0]   q_c;
		logic [DX_W-1:0]   d;
		logic [TICK_W-1:0] t1;
		logic [TICK_W-1:0] t2;
		logic [TICK_W-1:0] t0;
		logic [2:0]        k;
		logic              sat;
		logic              inv;
	} ddiv_t;

	typedef struct packed {
		logic              valid_res;
		logic [2:0]        sector;
		logic [TICK_W-1:0] active_time_one;
		logic [TICK_W-1:0] active_time_two;
		logic [TICK_W-1:0] zero_time;
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		logic [DUTY_W-1:0] duty_c;
		logic              saturated;
	} res_t;

endpackage

// ----- rtl/space_vector_pwm_timing_top.sv -----
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------
// in        | in_valid / in_ready     | volt_alpha, volt_beta, bus_volt
// out       | out_valid / out_ready   | valid_res, sector, times, duties, saturated
// cfg (APB) | psel/penable/pready     | paddr, pwdata, prdata (period_ticks at 0)
//
// One request per cycle sustained while the output buffer has room. The path to the output register
// runs through the 16-step time divider and the 17-step duty divider, one quotient
// bit per stage each.
// A two-entry output buffer lets the pipeline keep moving while one result waits;
// the whole pipeline holds only when both entries are full.
// Reset clears the valid bits and the buffer count and loads a period of 5000.
module space_vector_pwm_timing_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [15:0]          volt_alpha,
	input  logic signed [15:0]          volt_beta,
	input  logic [svpt_pkg::VDC_W-1:0]  bus_volt,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        valid_res,
	output logic [2:0]                  sector,
	output logic [svpt_pkg::TICK_W-1:0] active_time_one,
	output logic [svpt_pkg::TICK_W-1:0] active_time_two,
	output logic [svpt_pkg::TICK_W-1:0] zero_time,
	output logic [svpt_pkg::DUTY_W-1:0] duty_a,
	output logic [svpt_pkg::DUTY_W-1:0] duty_b,
	output logic [svpt_pkg::DUTY_W-1:0] duty_c,
	output logic                        saturated,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import svpt_pkg::*;

	localparam int TSTEPS = TQ_W;
	localparam int DSTEPS = DQ_W;

	// ---------------- configuration ----------------
	logic [TICK_W-1:0] period_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
		end else if (psel && penable && pwrite && pready &&
			reg_idx_t'(paddr[2]) == REG_PERIOD) begin
			period_q <= pwdata[TICK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx_t'(paddr[2]) == REG_PERIOD)
			prdata = {{(32-TICK_W){1'b0}}, period_q};
	end

	// ---------------- pipeline control ----------------
	logic [1:0] cnt_q;
	logic       en;

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	// ---------------- stage 1: products ----------------
	logic                    v_s1;
	logic signed [15:0]      a_s1;
	logic signed [U_W-1:0]   u_s1;
	logic [31:0]             aa_s1;
	logic [31:0]             bb_s1;
	logic                    bs_s1, bz_s1;
	logic [VDC_W-1:0]        vdc_s1;
	logic [TICK_W-1:0]       ts_s1;
	logic                    inv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= volt_alpha;
			u_s1   <= U_W'(volt_beta * $signed({1'b0, SQRT3_Q24}));
			aa_s1  <= 32'(volt_alpha * volt_alpha);
			bb_s1  <= 32'(volt_beta * volt_beta);
			bs_s1  <= volt_beta[15];
			bz_s1  <= (volt_beta == 16'sd0);
			vdc_s1 <= bus_volt;
			ts_s1  <= period_q;
			inv_s1 <= (bus_volt == '0) || (period_q == '0);
		end
	end

	// ---------------- stage 2: sector ----------------
	logic                  v_s2;
	logic signed [15:0]    a_s2;
	logic signed [U_W-1:0] u_s2;
	logic [2:0]            k_s2;
	logic [VDC_W-1:0]      vdc_s2;
	logic [TICK_W-1:0]     ts_s2;
	logic                  inv_s2;

	// sign of (sqrt3*b - c) from signs of b, c and of 3b^2 - c^2
	function automatic logic signed [1:0] srm(input logic signed [1:0] sb,
		input logic signed [1:0] sc, input logic signed [1:0] d);
		logic signed [1:0] r;
		if (sb >= 0 && sc <= 0)
			r = (sb == 0 && sc == 0) ? 2'sd0 : 2'sd1;
		else if (sb <= 0 && sc >= 0)
			r = -2'sd1;
		else
			r = (sb > 0) ? d : -d;
		return r;
	endfunction

	logic signed [1:0]  sp [6];
	logic signed [1:0]  sgn_b, sgn_a, sgn_d;
	logic signed [35:0] diff;
	logic [2:0]         k_c;

	always_comb begin
		sgn_b = bz_s1 ? 2'sd0 : (bs_s1 ? -2'sd1 : 2'sd1);
		sgn_a = (a_s1 == 16'sd0) ? 2'sd0 : (a_s1[15] ? -2'sd1 : 2'sd1);
		diff  = $signed({2'b0, 34'(bb_s1) * 34'd3}) - $signed({2'b0, 34'(aa_s1) * 34'd9});
		sgn_d = (diff == 36'sd0) ? 2'sd0 : (diff[35] ? -2'sd1 : 2'sd1);
		sp[0] = sgn_b;
		sp[1] = srm(sgn_b, sgn_a, sgn_d);
		sp[2] = -srm(sgn_b, -sgn_a, sgn_d);
		sp[3] = -sp[0];
		sp[4] = -sp[1];
		sp[5] = -sp[2];
		k_c = 3'd5;
		// lowest edge crossing wins
		for (int i = 5; i >= 0; i--) begin
			if (sp[i] >= 0 && sp[(i + 1) % 6] < 0)
				k_c = 3'(i);
		end
		if (a_s1 == 16'sd0 && bz_s1)
			k_c = 3'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_s1;
			u_s2   <= u_s1;
			k_s2   <= k_c;
			vdc_s2 <= vdc_s1;
			ts_s2  <= ts_s1;
			inv_s2 <= inv_s1;
		end
	end

	// ---------------- stage 3: edge projections ----------------
	logic                v_s3;
	logic [W_W-1:0]      w1_s3, w2_s3;
	logic [DEN_W-1:0]    den_s3;
	logic [TICK_W-1:0]   ts_s3;
	logic [2:0]          k_s3;
	logic                inv_s3;

	logic signed [P_W-1:0] a3, uu, w1s, w2s;
	logic signed [P_W-1:0] p [6];

	always_comb begin
		a3   = (P_W'(a_s2) * P_W'(3)) <<< FRAC_W;
		uu   = P_W'(u_s2);
		p[0] = uu <<< 1;
		p[1] = uu - a3;
		p[2] = -uu - a3;
		p[3] = -(uu <<< 1);
		p[4] = a3 - uu;
		p[5] = a3 + uu;
		w2s  = p[0];
		w1s  = -p[1];
		case (k_s2)
			3'd0: begin w2s = p[0]; w1s = -p[1]; end
			3'd1: begin w2s = p[1]; w1s = -p[2]; end
			3'd2: begin w2s = p[2]; w1s = -p[3]; end
			3'd3: begin w2s = p[3]; w1s = -p[4]; end
			3'd4: begin w2s = p[4]; w1s = -p[5]; end
			3'd5: begin w2s = p[5]; w1s = -p[0]; end
			default: begin w2s = p[0]; w1s = -p[1]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w1_s3  <= (w1s > 0) ? w1s[W_W-1:0] : '0;
			w2_s3  <= (w2s > 0) ? w2s[W_W-1:0] : '0;
			den_s3 <= {vdc_s2, {(FRAC_W + 1){1'b0}}};
			ts_s3  <= ts_s2;
			k_s3   <= k_s2;
			inv_s3 <= inv_s2;
		end
	end

	// ---------------- stage 4: partial products, overmodulation ----------------
	logic                v_s4;
	logic [PP_W-1:0]     m1l_s4, m1h_s4, m2l_s4, m2h_s4;
	logic [SUM_W-1:0]    sum_s4;
	logic [DEN_W-1:0]    den_s4;
	logic                sat_s4;
	logic [TICK_W-1:0]   ts_s4;
	logic [2:0]          k_s4;
	logic                inv_s4;
	logic [SUM_W-1:0]    sum_c;

	assign sum_c = SUM_W'(w1_s3) + SUM_W'(w2_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			m1l_s4 <= PP_W'(ts_s3 * w1_s3[HALF_W-1:0]);
			m1h_s4 <= PP_W'(ts_s3 * w1_s3[W_W-1:HALF_W]);
			m2l_s4 <= PP_W'(ts_s3 * w2_s3[HALF_W-1:0]);
			m2h_s4 <= PP_W'(ts_s3 * w2_s3[W_W-1:HALF_W]);
			sum_s4 <= sum_c;
			den_s4 <= den_s3;
			sat_s4 <= sum_c > SUM_W'(den_s3);
			ts_s4  <= ts_s3;
			k_s4   <= k_s3;
			inv_s4 <= inv_s3;
		end
	end

	// ---------------- time divider: one quotient bit per stage ----------------
	logic  tv_s5 [TSTEPS+1];
	tdiv_t td_s5 [TSTEPS+1];

	function automatic tdiv_t tstep(input tdiv_t x, input int m);
		tdiv_t            y;
		logic [REM_W-1:0] sh1, sh2;
		int               bitn;
		bitn = TSTEPS - 1 - m;
		y    = x;
		sh1  = REM_W'(x.d1) << bitn;
		sh2  = REM_W'(x.d2) << bitn;
		if (x.rem1 >= sh1) begin
			y.rem1       = x.rem1 - sh1;
			y.q1[bitn]   = 1'b1;
		end
		if (x.rem2 >= sh2) begin
			y.rem2       = x.rem2 - sh2;
			y.q2[bitn]   = 1'b1;
		end
		return y;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			td_s5[0].rem1 <= REM_W'(m1l_s4) + (REM_W'(m1h_s4) << HALF_W);
			td_s5[0].rem2 <= REM_W'(m2l_s4) + (REM_W'(m2h_s4) << HALF_W);
			td_s5[0].q1   <= '0;
			td_s5[0].q2   <= '0;
			td_s5[0].d1   <= sat_s4 ? sum_s4 : SUM_W'(den_s4);
			td_s5[0].d2   <= SUM_W'(den_s4);
			td_s5[0].ts   <= ts_s4;
			td_s5[0].k    <= k_s4;
			td_s5[0].sat  <= sat_s4;
			td_s5[0].inv  <= inv_s4;
			for (int m = 0; m < TSTEPS; m++)
				td_s5[m+1] <= tstep(td_s5[m], m);
		end
	end

	// ---------------- stage 6: times ----------------
	logic              v_s6;
	logic [TICK_W-1:0] t1_s6, t2_s6, t0_s6, ts_s6;
	logic [2:0]        k_s6;
	logic              sat_s6, inv_s6;
	tdiv_t             tl;

	assign tl = td_s5[TSTEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s6  <= tl.q1;
			t2_s6  <= tl.sat ? tl.ts - tl.q1 : tl.q2;
			t0_s6  <= tl.sat ? '0 : tl.ts - tl.q1 - tl.q2;
			ts_s6  <= tl.ts;
			k_s6   <= tl.k;
			sat_s6 <= tl.sat;
			inv_s6 <= tl.inv;
		end
	end

	// ---------------- duty divider ----------------
	logic  dv_s7 [DSTEPS+1];
	ddiv_t dd_s7 [DSTEPS+1];

	logic [DX_W-1:0] full2, x2, x0, xa, xb, xc;

	always_comb begin
		full2 = DX_W'(ts_s6) + DX_W'(t1_s6) + DX_W'(t2_s6);
		x0    = DX_W'(t0_s6);
		x2    = k_s6[0] ? (DX_W'(t1_s6) << 1) + x0 : (DX_W'(t2_s6) << 1) + x0;
		case (k_s6)
			3'd0: begin xa = full2; xb = x2;    xc = x0;    end
			3'd1: begin xa = x2;    xb = full2; xc = x0;    end
			3'd2: begin xa = x0;    xb = full2; xc = x2;    end
			3'd3: begin xa = x0;    xb = x2;    xc = full2; end
			3'd4: begin xa = x2;    xb = x0;    xc = full2; end
			default: begin xa = full2; xb = x0; xc = x2;   end
		endcase
	end

	function automatic ddiv_t dstep(input ddiv_t x, input int m);
		ddiv_t           y;
		logic [DN_W-1:0] sh;
		int              bitn;
		bitn = DSTEPS - 1 - m;
		y    = x;
		sh   = DN_W'(x.d) << bitn;
		if (x.rem_a >= sh) begin
			y.rem_a     = x.rem_a - sh;
			y.q_a[bitn] = 1'b1;
		end
		if (x.rem_b >= sh) begin
			y.rem_b     = x.rem_b - sh;
			y.q_b[bitn] = 1'b1;
		end
		if (x.rem_c >= sh) begin
			y.rem_c     = x.rem_c - sh;
			y.q_c[bitn] = 1'b1;
		end
		return y;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			// round(x * 2^DUTY_W / (2*Ts))
			dd_s7[0].rem_a <= (DN_W'(xa) << DUTY_W) + DN_W'(ts_s6);
			dd_s7[0].rem_b <= (DN_W'(xb) << DUTY_W) + DN_W'(ts_s6);
			dd_s7[0].rem_c <= (DN_W'(xc) << DUTY_W) + DN_W'(ts_s6);
			dd_s7[0].q_a   <= '0;
			dd_s7[0].q_b   <= '0;
			dd_s7[0].q_c   <= '0;
			dd_s7[0].d     <= DX_W'(ts_s6) << 1;
			dd_s7[0].t1    <= t1_s6;
			dd_s7[0].t2    <= t2_s6;
			dd_s7[0].t0    <= t0_s6;
			dd_s7[0].k     <= k_s6;
			dd_s7[0].sat   <= sat_s6;
			dd_s7[0].inv   <= inv_s6;
			for (int m = 0; m < DSTEPS; m++)
				dd_s7[m+1] <= dstep(dd_s7[m], m);
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s6 <= 1'b0;
			for (int m = 0; m <= TSTEPS; m++)
				tv_s5[m] <= 1'b0;
			for (int m = 0; m <= DSTEPS; m++)
				dv_s7[m] <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			tv_s5[0] <= v_s4;
			for (int m = 0; m < TSTEPS; m++)
				tv_s5[m+1] <= tv_s5[m];
			v_s6     <= tv_s5[TSTEPS];
			dv_s7[0] <= v_s6;
			for (int m = 0; m < DSTEPS; m++)
				dv_s7[m+1] <= dv_s7[m];
		end
	end

	// ---------------- result and output buffer ----------------
	ddiv_t dl;
	res_t  res_c, head_q, skid_q;
	logic  push, pop;

	function automatic logic [DUTY_W-1:0] clamp(input logic [DQ_W-1:0] q);
		return (q > DQ_W'(DUTY_FULL)) ? DUTY_FULL : q[DUTY_W-1:0];
	endfunction

	always_comb begin
		dl = dd_s7[DSTEPS];
		res_c = '0;
		if (!dl.inv) begin
			res_c.valid_res       = 1'b1;
			res_c.sector          = dl.k + 3'd1;
			res_c.active_time_one = dl.t1;
			res_c.active_time_two = dl.t2;
			res_c.zero_time       = dl.t0;
			res_c.duty_a          = clamp(dl.q_a);
			res_c.duty_b          = clamp(dl.q_b);
			res_c.duty_c          = clamp(dl.q_c);
			res_c.saturated       = dl.sat;
		end
	end

	assign push = en && dv_s7[DSTEPS];
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (pop && cnt_q == 2'd1)))
			head_q <= res_c;
		else if (pop)
			head_q <= skid_q;
		if (push && !pop && cnt_q == 2'd1)
			skid_q <= res_c;
	end

	assign out_valid       = (cnt_q != 2'd0);
	assign valid_res       = head_q.valid_res;
	assign sector          = head_q.sector;
	assign active_time_one = head_q.active_time_one;
	assign active_time_two = head_q.active_time_two;
	assign zero_time       = head_q.zero_time;
	assign duty_a          = head_q.duty_a;
	assign duty_b          = head_q.duty_b;
	assign duty_c          = head_q.duty_c;
	assign saturated       = head_q.saturated;

endmodule

// ----- rtl/svpt_chk.sv -----
module svpt_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        valid_res,
	input logic [2:0]                  sector,
	input logic [svpt_pkg::TICK_W-1:0] zero_time,
	input logic [svpt_pkg::DUTY_W-1:0] duty_a,
	input logic [svpt_pkg::DUTY_W-1:0] duty_b,
	input logic [svpt_pkg::DUTY_W-1:0] duty_c,
	input logic                        saturated
);
	import svpt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sector) && $stable(duty_a))
		else $error("stalled result changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> sector == 3'd0 && !saturated && zero_time == '0 &&
		duty_a == '0 && duty_b == '0 && duty_c == '0)
		else $error("invalid result carries nonzero fields");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> sector != 3'd0 && sector != 3'd7)
		else $error("sector out of range");

	a_sat_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res && saturated |-> zero_time == '0)
		else $error("overmodulated result has zero time");

endmodule

bind space_vector_pwm_timing_top svpt_chk u_svpt_chk (.*);

// ----- tb/sv/tb_space_vector_pwm_timing_top.sv -----
module tb_space_vector_pwm_timing_top;
	timeunit 1ns;
	timeprecision 1ps;
	import svpt_pkg::*;

	localparam longint SQ3 = 64'd29058991;
	localparam int LATENCY = 60;
	localparam int WDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] volt_alpha, volt_beta;
	logic [VDC_W-1:0] bus_volt;
	logic valid_res, saturated;
	logic [2:0] sector;
	logic [TICK_W-1:0] active_time_one, active_time_two, zero_time;
	logic [DUTY_W-1:0] duty_a, duty_b, duty_c;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	space_vector_pwm_timing_top i_dut (.*);

	typedef struct {
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [VDC_W-1:0]   vdc;
		logic               has_res;
		res_t               res;
	} vec_row_t;

	res_t pending_timing[$];
	logic [TICK_W-1:0] period_reg;
	int errors;
	int sent, received, saturations, sector_seen[7];
	int idle_in_pct, idle_out_pct;
	bit hold_out;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
	end
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int sgn(longint x);
		return (x > 0) - (x < 0);
	endfunction

	// sign of sqrt3*b - c, exact
	function automatic int root3_sign(longint b, longint c);
		int sb, sc, d;
		sb = sgn(b);
		sc = sgn(c);
		if (sb >= 0 && sc <= 0)
			return (sb == 0 && sc == 0) ? 0 : 1;
		if (sb <= 0 && sc >= 0)
			return -1;
		d = sgn(3 * b * b - c * c);
		return (b > 0) ? d : -d;
	endfunction

	function automatic logic [15:0] duty_from(longint unsigned twice_on, longint unsigned ts);
		longint unsigned d;
		d = (twice_on * 65536 + ts) / (2 * ts);
		return d > 65535 ? 16'hFFFF : d[15:0];
	endfunction

	function automatic res_t svpwm_timing(logic signed [15:0] va, logic signed [15:0] vb,
			logic [VDC_W-1:0] vdc, logic [TICK_W-1:0] period);
		res_t r;
		longint a, b, u, a3, w1s, w2s;
		longint p[6];
		int sp[6];
		int k;
		longint unsigned w1, w2, den, ts, t1, t2, t0, full2, x2, da, db, dc;
		r = '0;
		a = va;
		b = vb;
		ts = period;
		if (vdc == 0 || period == 0)
			return r;
		sp[0] = sgn(b);
		sp[1] = root3_sign(b, 3 * a);
		sp[2] = -root3_sign(b, -3 * a);
		sp[3] = -sp[0];
		sp[4] = -sp[1];
		sp[5] = -sp[2];
		k = 5;
		if (a == 0 && b == 0) begin
			k = 0;
		end else begin
			for (int i = 5; i >= 0; i--)
				if (sp[i] >= 0 && sp[(i + 1) % 6] < 0)
					k = i;
		end
		u = b * SQ3;
		a3 = 3 * a * (64'sd1 <<< 24);
		p[0] = 2 * u;
		p[1] = u - a3;
		p[2] = -u - a3;
		p[3] = -2 * u;
		p[4] = a3 - u;
		p[5] = a3 + u;
		w2s = p[k];
		w1s = -p[(k + 1) % 6];
		w1 = w1s > 0 ? w1s : 0;
		w2 = w2s > 0 ? w2s : 0;
		den = longint'(vdc) << 25;
		if (w1 + w2 > den) begin
			t1 = (ts * w1) / (w1 + w2);
			t2 = ts - t1;
			t0 = 0;
			r.saturated = 1'b1;
		end else begin
			t1 = (ts * w1) / den;
			t2 = (ts * w2) / den;
			t0 = ts - t1 - t2;
		end
		full2 = 2 * (t1 + t2) + t0;
		x2 = (k % 2 == 0) ? 2 * t2 + t0 : 2 * t1 + t0;
		case (k)
			0: begin da = full2; db = x2; dc = t0; end
			1: begin da = x2; db = full2; dc = t0; end
			2: begin da = t0; db = full2; dc = x2; end
			3: begin da = t0; db = x2; dc = full2; end
			4: begin da = x2; db = t0; dc = full2; end
			default: begin da = full2; db = t0; dc = x2; end
		endcase
		r.valid_res = 1'b1;
		r.sector = 3'(k + 1);
		r.active_time_one = t1[15:0];
		r.active_time_two = t2[15:0];
		r.zero_time = t0[15:0];
		r.duty_a = duty_from(da, ts);
		r.duty_b = duty_from(db, ts);
		r.duty_c = duty_from(dc, ts);
		return r;
	endfunction

	task automatic write_period(logic [TICK_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {REG_PERIOD, 2'b00};
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		period_reg = value;
		// read back
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== value) begin
			$error("period_ticks readback: expected %0d actual %0d", value, prdata[15:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_vector(logic signed [15:0] va, logic signed [15:0] vb,
			logic [VDC_W-1:0] vdc, bit typed, res_t typed_res);
		res_t r;
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		r = svpwm_timing(va, vb, vdc, period_reg);
		if (typed && r !== typed_res) begin
			$error("predictor disagrees with directed row %0d %0d %0d", va, vb, vdc);
			errors++;
		end
		in_valid <= 1'b1;
		volt_alpha <= va;
		volt_beta <= vb;
		bus_volt <= vdc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_timing.push_back(typed ? typed_res : r);
		sent++;
	endtask

	task automatic drain;
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_timing.size() != 0)
			@(posedge clk);
		while (n < LATENCY) begin
			@(posedge clk);
			n++;
		end
	endtask

	task automatic random_vectors(int count);
		logic signed [15:0] va, vb;
		logic [VDC_W-1:0] vdc;
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(9);
			vdc = VDC_W'($urandom);
			if (mode == 0)
				vdc = VDC_W'($urandom_range(3));
			va = 16'($urandom);
			vb = 16'($urandom);
			// four modes in ten keep the vector small against vdc so T0 mostly stays positive
			if (mode >= 4 && mode < 8) begin
				vdc = VDC_W'($urandom_range(32767, 1000));
				va = $signed(16'($urandom_range(2 * (vdc / 2), 0))) - $signed(16'(vdc / 2));
				vb = $signed(16'($urandom_range(2 * (vdc / 2), 0))) - $signed(16'(vdc / 2));
			end else if (mode == 8) begin
				va = $signed(16'($urandom_range(64))) - 16'sd32;
				vb = $signed(16'($urandom_range(64))) - 16'sd32;
			end
			send_vector(va, vb, vdc, 1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_timing.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = pending_timing.pop_front();
				received++;
				if (valid_res) sector_seen[sector]++;
				if (saturated) saturations++;
				if (valid_res !== want.valid_res) begin
					$error("valid_res expected %0d actual %0d", want.valid_res, valid_res);
					errors++;
				end
				if (sector !== want.sector) begin
					$error("sector expected %0d actual %0d", want.sector, sector);
					errors++;
				end
				if (active_time_one !== want.active_time_one) begin
					$error("active_time_one expected %0d actual %0d",
						want.active_time_one, active_time_one);
					errors++;
				end
				if (active_time_two !== want.active_time_two) begin
					$error("active_time_two expected %0d actual %0d",
						want.active_time_two, active_time_two);
					errors++;
				end
				if (zero_time !== want.zero_time) begin
					$error("zero_time expected %0d actual %0d", want.zero_time, zero_time);
					errors++;
				end
				if (duty_a !== want.duty_a) begin
					$error("duty_a expected %0d actual %0d", want.duty_a, duty_a);
					errors++;
				end
				if (duty_b !== want.duty_b) begin
					$error("duty_b expected %0d actual %0d", want.duty_b, duty_b);
					errors++;
				end
				if (duty_c !== want.duty_c) begin
					$error("duty_c expected %0d actual %0d", want.duty_c, duty_c);
					errors++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated expected %0d actual %0d", want.saturated, saturated);
					errors++;
				end
			end
		end
	end

	// receiver ready, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_out)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= idle_out_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("space_vector_pwm_timing_top regression: fail");
			$finish;
		end
	end

	vec_row_t vec_table[$];

	function automatic res_t fixed_res(logic [2:0] sec, logic [15:0] t1, logic [15:0] t2,
			logic [15:0] t0, logic [15:0] da, logic [15:0] db, logic [15:0] dc);
		res_t r;
		r = '{1'b1, sec, t1, t2, t0, da, db, dc, 1'b0};
		return r;
	endfunction

	initial begin
		int hold_count;
		errors = 0;
		sent = 0;
		received = 0;
		saturations = 0;
		quiet_cycles = 0;
		hold_out = 1'b0;
		idle_in_pct = 24;
		idle_out_pct = 50;
		period_reg = PERIOD_RST;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		volt_alpha = '0;
		volt_beta = '0;
		bus_volt = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// zero bus voltage, zero vector, extremes, each sector, boundaries
		vec_table = '{
			'{16'sd0, 16'sd0, 15'd0, 1'b1, res_t'('0)},
			'{16'sd32767, -16'sd32768, 15'd0, 1'b1, res_t'('0)},
			'{16'sd0, 16'sd0, 15'd1000, 1'b1,
				fixed_res(3'd1, 16'd0, 16'd0, 16'd5000, 16'd32768, 16'd32768, 16'd32768)},
			'{16'sd100, 16'sd0, 15'd1000, 1'b0, res_t'('0)},
			'{16'sd100, 16'sd100, 15'd1000, 1'b0, res_t'('0)},
			'{-16'sd100, 16'sd100, 15'd1000, 1'b0, res_t'('0)},
			'{-16'sd100, 16'sd0, 15'd1000, 1'b0, res_t'('0)},
			'{-16'sd100, -16'sd100, 15'd1000, 1'b0, res_t'('0)},
			'{16'sd100, -16'sd100, 15'd1000, 1'b0, res_t'('0)},
			'{16'sd0, 16'sd100, 15'd1000, 1'b0, res_t'('0)},
			'{16'sd0, -16'sd100, 15'd1000, 1'b0, res_t'('0)},
			'{16'sd1, 16'sd0, 15'd32767, 1'b0, res_t'('0)},
			'{16'sd32767, 16'sd32767, 15'd1, 1'b0, res_t'('0)},
			'{-16'sd32768, -16'sd32768, 15'd32767, 1'b0, res_t'('0)},
			'{-16'sd32768, 16'sd32767, 15'd16384, 1'b0, res_t'('0)},
			'{16'sd32767, -16'sd1, 15'd32767, 1'b0, res_t'('0)},
			'{16'sd500, 16'sd0, 15'd100, 1'b0, res_t'('0)},
			'{16'sd10000, 16'sd5000, 15'd32767, 1'b0, res_t'('0)}
		};
		foreach (vec_table[i])
			send_vector(vec_table[i].alpha, vec_table[i].beta, vec_table[i].vdc,
				vec_table[i].has_res, vec_table[i].res);
		drain();

		write_period(16'd1);
		send_vector(16'sd0, 16'sd0, 15'd5, 1'b1,
			fixed_res(3'd1, 16'd0, 16'd0, 16'd1, 16'd32768, 16'd32768, 16'd32768));
		random_vectors(80);
		drain();

		write_period(16'd0);
		send_vector(16'sd300, 16'sd300, 15'd500, 1'b1, res_t'('0));
		random_vectors(20);
		drain();

		write_period(16'd65535);
		random_vectors(150);

		// block the output for a long stretch while requests keep coming
		hold_out = 1'b1;
		fork
			random_vectors(60);
			begin
				hold_count = 0;
				while (hold_count < 400) begin
					@(posedge clk);
					hold_count++;
				end
				hold_out = 1'b0;
			end
		join
		drain();

		idle_in_pct = 50;
		idle_out_pct = 24;
		write_period(16'd3);
		random_vectors(100);
		drain();
		write_period(16'd1234);
		random_vectors(120);
		drain();

		idle_in_pct = 0;
		idle_out_pct = 0;
		write_period(16'd5000);
		random_vectors(150);
		drain();

		$display("covered %0d vectors, %0d results, %0d saturated, periods 0,1,3,1234,5000,65535",
			sent, received, saturations);
		$display("sector hits 1..6: %0d %0d %0d %0d %0d %0d", sector_seen[1], sector_seen[2],
			sector_seen[3], sector_seen[4], sector_seen[5], sector_seen[6]);
		if (errors == 0)
			$display("space_vector_pwm_timing_top regression: pass");
		else
			$display("space_vector_pwm_timing_top regression: fail");
		$finish;
	end

endmodule
